### rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_USED = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int PAGE_COUNT_W  = 8;
    localparam int FRAME_INDEX_W = 12;
    localparam int STATUS_W      = 2;
    localparam int ORDER_OUT_W   = 3;

    typedef struct packed {
        logic init_step;
        logic load;
        logic alloc_start;
        logic rd;
        logic rd_buddy;
        logic take;
        logic scan_next;
        logic split_step;
        logic alloc_fin;
        logic free_clear;
        logic merge;
        logic free_fin;
        logic res_bad;
        logic res_empty;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic alloc_bad;
        logic alloc_none;
        logic scan_hit;
        logic scan_last;
        logic split_done;
        logic free_oob;
        logic head_ok;
        logic merge_try;
        logic buddy_ok;
    } stat_t;

endpackage
`default_nettype wire

### rtl/bpa_datapath.sv
`default_nettype none
module bpa_datapath #(
    parameter int NUM_FRAMES  = 4096,
    parameter int ORDER_LIMIT = 7
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [bpa_pkg::PAGE_COUNT_W-1:0]    page_count,
    input  wire logic [bpa_pkg::FRAME_INDEX_W-1:0]   frame_index,
    input  wire bpa_pkg::cmd_t                       cmd,
    output bpa_pkg::stat_t                           stat,
    output logic [bpa_pkg::STATUS_W-1:0]             status,
    output logic [bpa_pkg::FRAME_INDEX_W-1:0]        block_frame,
    output logic [bpa_pkg::ORDER_OUT_W-1:0]          block_order
);

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int OW    = $clog2(ORDER_LIMIT + 1);
    localparam int EW    = OW + 2;
    localparam int CW    = $clog2(NUM_FRAMES + 1);
    localparam int PW    = ((IDX_W > ORDER_LIMIT) ? IDX_W : ORDER_LIMIT) + 2;
    localparam int NW    = ((ORDER_LIMIT > bpa_pkg::PAGE_COUNT_W) ?
                            ORDER_LIMIT : bpa_pkg::PAGE_COUNT_W) + 2;
    localparam int AW    = ((IDX_W > bpa_pkg::FRAME_INDEX_W) ?
                            IDX_W : bpa_pkg::FRAME_INDEX_W) + 1;

    logic [EW-1:0]    mem [0:NUM_FRAMES-1];
    logic [EW-1:0]    rdata_reg;

    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [OW-1:0]    k_reg, k_next;
    logic [OW-1:0]    want_reg, want_next;
    logic             bad_reg, bad_next;
    logic             oob_reg, oob_next;
    logic [IDX_W-1:0] init_addr_reg, init_addr_next;
    logic [PW-1:0]    next_head_reg, next_head_next;
    logic [CW-1:0]    cnt_reg [0:ORDER_LIMIT];

    logic [bpa_pkg::STATUS_W-1:0]      status_reg;
    logic [bpa_pkg::FRAME_INDEX_W-1:0] frame_reg;
    logic [bpa_pkg::ORDER_OUT_W-1:0]   order_reg;

    logic [OW-1:0]    want_c, found_c, init_k;
    logic             bad_c, any_c;
    logic [PW-1:0]    cur_pos, step, half, next_pos, upper, buddy, init_pos;
    logic             upper_in, init_head;
    logic [1:0]       rd_kind;
    logic [OW-1:0]    rd_ord;

    logic             we;
    logic [IDX_W-1:0] addr;
    logic [EW-1:0]    wdata;

    always_comb
    begin
        want_c = '0;
        for (int j = ORDER_LIMIT; j >= 0; j--)
        begin
            if (NW'(page_count) <= (NW'(1) << j))
                want_c = OW'(j);
        end
        bad_c = (page_count == '0) || (NW'(page_count) > (NW'(1) << ORDER_LIMIT));

        found_c = '0;
        any_c   = 1'b0;
        for (int j = ORDER_LIMIT; j >= 0; j--)
        begin
            if (OW'(j) >= want_reg && cnt_reg[j] != '0)
            begin
                found_c = OW'(j);
                any_c   = 1'b1;
            end
        end

        cur_pos  = PW'(cur_idx_reg);
        step     = PW'(1) << k_reg;
        half     = PW'(1) << (k_reg - OW'(1));
        next_pos = cur_pos + step;
        upper    = cur_pos + half;
        buddy    = cur_pos ^ step;
        upper_in = upper < PW'(NUM_FRAMES);

        init_pos  = PW'(init_addr_reg);
        init_head = init_pos == next_head_reg;
        init_k    = '0;
        for (int j = 0; j <= ORDER_LIMIT; j++)
        begin
            if ((init_pos & ((PW'(1) << j) - PW'(1))) == '0 &&
                (init_pos + (PW'(1) << j)) <= PW'(NUM_FRAMES))
                init_k = OW'(j);
        end

        rd_kind = rdata_reg[EW-1:OW];
        rd_ord  = rdata_reg[OW-1:0];
    end

    always_comb
    begin
        stat.init_last  = init_addr_reg == IDX_W'(NUM_FRAMES - 1);
        stat.alloc_bad  = bad_reg;
        stat.alloc_none = !any_c;
        stat.scan_hit   = rd_kind == bpa_pkg::KIND_FREE && rd_ord == k_reg;
        stat.scan_last  = next_pos >= PW'(NUM_FRAMES);
        stat.split_done = k_reg == want_reg;
        stat.free_oob   = oob_reg;
        stat.head_ok    = rd_kind == bpa_pkg::KIND_USED && rd_ord <= OW'(ORDER_LIMIT);
        stat.merge_try  = k_reg < OW'(ORDER_LIMIT) && buddy < PW'(NUM_FRAMES);
        stat.buddy_ok   = rd_kind == bpa_pkg::KIND_FREE && rd_ord == k_reg;
    end

    // single memory port
    always_comb
    begin
        we    = 1'b0;
        addr  = cur_idx_reg;
        wdata = {bpa_pkg::KIND_NONE, {OW{1'b0}}};
        if (cmd.init_step)
        begin
            we    = 1'b1;
            addr  = init_addr_reg;
            wdata = init_head ? {bpa_pkg::KIND_FREE, init_k}
                              : {bpa_pkg::KIND_NONE, {OW{1'b0}}};
        end
        else if (cmd.split_step)
        begin
            we    = upper_in;
            addr  = upper[IDX_W-1:0];
            wdata = {bpa_pkg::KIND_FREE, k_reg - OW'(1)};
        end
        else if (cmd.alloc_fin)
        begin
            we    = 1'b1;
            wdata = {bpa_pkg::KIND_USED, want_reg};
        end
        else if (cmd.free_clear)
        begin
            we = 1'b1;
        end
        else if (cmd.merge)
        begin
            we   = 1'b1;
            addr = buddy[IDX_W-1:0];
        end
        else if (cmd.free_fin)
        begin
            we    = 1'b1;
            wdata = {bpa_pkg::KIND_FREE, k_reg};
        end
        else if (cmd.rd_buddy)
        begin
            addr = buddy[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (cmd.rd || cmd.rd_buddy)
            rdata_reg <= mem[addr];
    end

    always_comb
    begin
        cur_idx_next   = cur_idx_reg;
        k_next         = k_reg;
        want_next      = want_reg;
        bad_next       = bad_reg;
        oob_next       = oob_reg;
        init_addr_next = init_addr_reg;
        next_head_next = next_head_reg;
        if (cmd.init_step)
        begin
            init_addr_next = init_addr_reg + IDX_W'(1);
            if (init_head)
                next_head_next = init_pos + (PW'(1) << init_k);
        end
        if (cmd.load)
        begin
            want_next    = want_c;
            bad_next     = bad_c;
            oob_next     = AW'(frame_index) >= AW'(NUM_FRAMES);
            cur_idx_next = IDX_W'(frame_index);
        end
        if (cmd.alloc_start)
        begin
            k_next       = found_c;
            cur_idx_next = '0;
        end
        if (cmd.scan_next)
            cur_idx_next = next_pos[IDX_W-1:0];
        if (cmd.split_step)
            k_next = k_reg - OW'(1);
        if (cmd.free_clear)
            k_next = rd_ord;
        if (cmd.merge)
        begin
            cur_idx_next = cur_idx_reg & ~step[IDX_W-1:0];
            k_next       = k_reg + OW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_idx_reg   <= '0;
            k_reg         <= '0;
            want_reg      <= '0;
            bad_reg       <= 1'b0;
            oob_reg       <= 1'b0;
            init_addr_reg <= '0;
            next_head_reg <= '0;
            for (int j = 0; j <= ORDER_LIMIT; j++)
                cnt_reg[j] <= '0;
        end
        else
        begin
            cur_idx_reg   <= cur_idx_next;
            k_reg         <= k_next;
            want_reg      <= want_next;
            bad_reg       <= bad_next;
            oob_reg       <= oob_next;
            init_addr_reg <= init_addr_next;
            next_head_reg <= next_head_next;
            if (cmd.init_step && init_head)
                cnt_reg[init_k] <= cnt_reg[init_k] + CW'(1);
            if (cmd.take)
                cnt_reg[k_reg] <= cnt_reg[k_reg] - CW'(1);
            if (cmd.split_step && upper_in)
                cnt_reg[k_reg - OW'(1)] <= cnt_reg[k_reg - OW'(1)] + CW'(1);
            if (cmd.merge && cnt_reg[k_reg] != '0)
                cnt_reg[k_reg] <= cnt_reg[k_reg] - CW'(1);
            if (cmd.free_fin)
                cnt_reg[k_reg] <= cnt_reg[k_reg] + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_bad || cmd.res_empty)
        begin
            status_reg <= cmd.res_bad ? bpa_pkg::ST_INVALID : bpa_pkg::ST_EMPTY;
            frame_reg  <= '0;
            order_reg  <= '0;
        end
        else if (cmd.alloc_fin)
        begin
            status_reg <= bpa_pkg::ST_OK;
            frame_reg  <= bpa_pkg::FRAME_INDEX_W'(cur_idx_reg);
            order_reg  <= bpa_pkg::ORDER_OUT_W'(want_reg);
        end
        else if (cmd.free_fin)
        begin
            status_reg <= bpa_pkg::ST_OK;
            frame_reg  <= bpa_pkg::FRAME_INDEX_W'(cur_idx_reg);
            order_reg  <= bpa_pkg::ORDER_OUT_W'(k_reg);
        end
    end

    assign status      = status_reg;
    assign block_frame = frame_reg;
    assign block_order = order_reg;

endmodule
`default_nettype wire

### rtl/bpa_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module bpa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire logic           action,
    output logic                res_valid,
    input  wire logic           res_ready,
    input  wire bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A_CHK  = 4'd2;
    localparam logic [3:0] S_A_RD   = 4'd3;
    localparam logic [3:0] S_A_TST  = 4'd4;
    localparam logic [3:0] S_A_SPL  = 4'd5;
    localparam logic [3:0] S_A_FIN  = 4'd6;
    localparam logic [3:0] S_F_CHK  = 4'd7;
    localparam logic [3:0] S_F_TST  = 4'd8;
    localparam logic [3:0] S_F_MRG  = 4'd9;
    localparam logic [3:0] S_F_BTST = 4'd10;
    localparam logic [3:0] S_F_FIN  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       res_cmd;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = action ? S_F_CHK : S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (stat.alloc_bad)
                begin
                    cmd.res_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.alloc_none)
                begin
                    cmd.res_empty = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.alloc_start = 1'b1;
                    state_next      = S_A_RD;
                end
            end
            S_A_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_A_TST;
            end
            S_A_TST:
            begin
                if (stat.scan_hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_A_SPL;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_empty = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_A_RD;
                end
            end
            S_A_SPL:
            begin
                if (stat.split_done)
                    state_next = S_A_FIN;
                else
                    cmd.split_step = 1'b1;
            end
            S_A_FIN:
            begin
                cmd.alloc_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_F_CHK:
            begin
                if (stat.free_oob)
                begin
                    cmd.res_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_F_TST;
                end
            end
            S_F_TST:
            begin
                if (stat.head_ok)
                begin
                    cmd.free_clear = 1'b1;
                    state_next     = S_F_MRG;
                end
                else
                begin
                    cmd.res_bad = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_F_MRG:
            begin
                if (stat.merge_try)
                begin
                    cmd.rd_buddy = 1'b1;
                    state_next   = S_F_BTST;
                end
                else
                    state_next = S_F_FIN;
            end
            S_F_BTST:
            begin
                if (stat.buddy_ok)
                begin
                    cmd.merge  = 1'b1;
                    state_next = S_F_MRG;
                end
                else
                    state_next = S_F_FIN;
            end
            S_F_FIN:
            begin
                cmd.free_fin = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res_cmd   = cmd.res_bad || cmd.res_empty || cmd.alloc_fin || cmd.free_fin;

    `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, res_valid, !req_ready)
    `ASSERT_NEXT(a_req_busy, clk, rst_n, req_valid && req_ready, !req_ready && !res_valid)
    `ASSERT_NEXT(a_res_idle, clk, rst_n, res_valid && res_ready, req_ready)
    `ASSERT_IMPLIES(a_one_result, clk, rst_n, res_cmd, state_next == S_DONE)

endmodule
`default_nettype wire

### rtl/buddy_page_allocator_core.sv
`default_nettype none
// Binary buddy page allocator. Each request (action 0 allocate page_count pages,
// action 1 free the block at frame_index) gives exactly one result with status,
// block_frame and block_order, and requests are handled one at a time. After
// reset the frame table memory is initialized entry by entry with req_ready low.
// An invalid or unsatisfiable allocate gives its result from the check; an
// allocate otherwise probes blocks of the chosen order from frame 0 upward (up to
// NUM_FRAMES probes at order 0) and then splits one level at a time down to the
// wanted order. An out-of-range free gives its result from the check and a free
// of a non-head frame after the head read; other frees merge one level per
// successful buddy probe until a probe fails or no buddy is left. The result
// stays on the outputs until taken, and a new request is accepted the cycle after.
module buddy_page_allocator_core #(
    parameter int NUM_FRAMES  = 4096,
    parameter int ORDER_LIMIT = 7
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire logic                               action,
    input  wire logic [bpa_pkg::PAGE_COUNT_W-1:0]   page_count,
    input  wire logic [bpa_pkg::FRAME_INDEX_W-1:0]  frame_index,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output logic [bpa_pkg::STATUS_W-1:0]            status,
    output logic [bpa_pkg::FRAME_INDEX_W-1:0]       block_frame,
    output logic [bpa_pkg::ORDER_OUT_W-1:0]         block_order
);

    bpa_pkg::cmd_t  cmd;
    bpa_pkg::stat_t stat;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (action),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_datapath #(
        .NUM_FRAMES  (NUM_FRAMES),
        .ORDER_LIMIT (ORDER_LIMIT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .page_count  (page_count),
        .frame_index (frame_index),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .block_frame (block_frame),
        .block_order (block_order)
    );

endmodule
`default_nettype wire
